// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock, off while in reset
`define GPDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define GPDW_ASSERT_NEVER(lbl, cond, msg) \
  `GPDW_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/gpdw_pkg.sv =====
package gpdw_pkg;

  localparam int unsigned DIV_QW = 32;
  localparam int unsigned DEN_W  = 64;
  localparam int unsigned SUM_W  = 48;

  localparam logic [1:0] CFG_HOP      = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_LEN      = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NOT_FRAME = 2'd1;
  localparam logic [1:0] ERR_PAINLESS  = 2'd2;
  localparam logic [1:0] ERR_ZERO_DIAG = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MOD,
    ST_LD_WR,
    ST_EM_MOD,
    ST_EM_MUL_LO,
    ST_EM_MUL_HI,
    ST_EM_CHK,
    ST_EM_DIV,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DEN_W:0]       rem_init;
    logic [DIV_QW-1:0]    bits;
    logic [DEN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_QW-1:0]    quot;
    logic [DEN_W:0]       rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gpdw_ram.sv =====
module gpdw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gpdw_div.sv =====
`include "assert_macros.svh"

// shift-subtract unit, one quotient bit a cycle; also gives the remainder
module gpdw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpdw_pkg::div_req_t req_i,
  output gpdw_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = gpdw_pkg::DIV_QW;
  localparam int unsigned DW = gpdw_pkg::DEN_W;
  localparam int unsigned CW = $clog2(QW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [QW-1:0] bits_q, bits_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q[DW-1:0], bits_q[QW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem_init;
      bits_d = req_i.bits;
      dvs_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      bits_d = {bits_q[QW-2:0], 1'b0};
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  `GPDW_ASSERT(a_rem_below_divisor, busy_q |-> (rem_q < {1'b0, dvs_q}), "remainder not below divisor")

endmodule

// ===== hw/rtl/gabor_painless_dual_window_core.sv =====
// channel | dir | handshake                 | payload
// s_axis  | in  | s_axis_tvalid/tready      | tdata: sample, tuser: kind
// m_axis  | out | m_axis_tvalid/tready      | tdata: dual_sample, tlast: last, tuser: error
// cfg     | in  | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
// a load beat writes the sample to the window store and, when the hop is valid,
// adds to a bin: the bin number comes from a 32-step remainder in the shared
// divider, then a read-modify-write of the bin memory.
// an emit beat runs the bin remainder, then the 16x48 product in two halves,
// then the quotient; the remainder and the quotient use the same divider.
// a result waits in the output register while the next beat is accepted.
// reset clears counters, state, output valid and bin valid bits; no clearing pass.
module gabor_painless_dual_window_core #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned MAX_HOP = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] dual_sample
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [1:0] error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned HW = (MAX_HOP > 1) ? $clog2(MAX_HOP) : 1;
  localparam int unsigned DW = gpdw_pkg::DEN_W;
  localparam int unsigned SW = gpdw_pkg::SUM_W;

  gpdw_pkg::state_e st_q, st_d;

  logic [8:0]  hop_q;
  logic [15:0] ch_q;
  logic [10:0] len_q;
  logic [10:0] lc_q, lc_d;
  logic [10:0] ec_q, ec_d;
  logic [MAX_HOP-1:0] vld_q, vld_d;

  logic [10:0] p_q, p_d;
  logic        upper_q, upper_d;
  logic [31:0] sq_q, sq_d;
  logic [HW-1:0] bin_q, bin_d;
  logic        last_q, last_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [15:0] smp_q, smp_d;
  logic [39:0] den_lo_q, den_lo_d;
  logic [DW-1:0] den_q, den_d;
  logic [31:0] res_q, res_d;
  logic [1:0]  rerr_q, rerr_d;

  logic        ov_q, ov_d;
  logic [31:0] od_q, od_d;
  logic        ol_q, ol_d;
  logic [1:0]  oe_q, oe_d;

  gpdw_pkg::div_req_t div_req;
  gpdw_pkg::div_rsp_t div_rsp;

  logic          win_we, win_re;
  logic [AW-1:0] win_addr;
  logic [15:0]   win_rdata;
  logic          dg_we, dg_re;
  logic [HW-1:0] dg_raddr;
  logic [SW-1:0] dg_wdata, dg_rdata;

  logic        s_acc, out_free, hop_ok, len_ok, ld_start;
  logic [10:0] ld_p, em_p;
  logic [11:0] half;
  logic        upper_now;
  logic [31:0] mod_arg;
  logic [8:0]  r9, bin9;
  logic [SW-1:0] cur_sum;
  logic [SW:0]   add_sum;
  logic [15:0] mag;
  logic        neg;
  logic [31:0] q;
  logic [1:0]  chk_err;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q <= 9'd1;
      ch_q  <= 16'd2;
      len_q <= 11'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gpdw_pkg::CFG_HOP:      hop_q <= cfg_data_i[8:0];
        gpdw_pkg::CFG_CHANNELS: ch_q  <= cfg_data_i;
        gpdw_pkg::CFG_LEN:      len_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (st_q == gpdw_pkg::ST_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign hop_ok   = (hop_q != 9'd0) && (32'(hop_q) <= MAX_HOP);
  assign len_ok   = (len_q != 11'd0) && (32'(len_q) <= MAX_LEN);
  assign ld_start = (lc_q >= len_q) || (32'(lc_q) >= MAX_LEN);
  assign ld_p     = ld_start ? 11'd0 : lc_q;
  assign em_p     = (ec_q >= len_q) ? 11'd0 : ec_q;
  assign half     = ({1'b0, len_q} + 12'd1) >> 1;

  // distance from the window end for the back half, position for the front
  always_comb begin
    logic [10:0] pp;
    pp        = (s_axis_tuser[0] == gpdw_pkg::KIND_LOAD) ? ld_p : em_p;
    upper_now = {1'b0, pp} >= half;
    mod_arg   = upper_now ? (32'(len_q) - 32'd1 - 32'(pp)) : 32'(pp);
  end

  assign r9   = div_rsp.rem[8:0];
  assign bin9 = upper_q ? (hop_q - 9'd1 - r9) : r9;

  assign cur_sum = vld_q[bin_q] ? dg_rdata : '0;
  assign add_sum = {1'b0, cur_sum} + (SW + 1)'(sq_q);
  assign neg     = smp_q[15];
  assign mag     = neg ? (~smp_q + 16'd1) : smp_q;
  assign q       = div_rsp.quot;

  always_comb begin
    if (hop_q == 9'd0 || 32'(hop_q) > MAX_HOP || ch_q <= 16'(hop_q) || len_q < 11'(hop_q)) begin
      chk_err = gpdw_pkg::ERR_NOT_FRAME;
    end else if (ch_q < 16'(len_q)) begin
      chk_err = gpdw_pkg::ERR_PAINLESS;
    end else begin
      chk_err = gpdw_pkg::ERR_OK;
    end
  end

  always_comb begin
    st_d     = st_q;
    lc_d     = lc_q;
    ec_d     = ec_q;
    vld_d    = vld_q;
    p_d      = p_q;
    upper_d  = upper_q;
    sq_d     = sq_q;
    bin_d    = bin_q;
    last_d   = last_q;
    sum_d    = sum_q;
    smp_d    = smp_q;
    den_lo_d = den_lo_q;
    den_d    = den_q;
    res_d    = res_q;
    rerr_d   = rerr_q;
    ov_d     = ov_q && !m_axis_tready;
    od_d     = od_q;
    ol_d     = ol_q;
    oe_d     = oe_q;
    win_we   = 1'b0;
    win_re   = 1'b0;
    win_addr = AW'(ld_p);
    dg_we    = 1'b0;
    dg_re    = 1'b0;
    dg_raddr = HW'(bin9);
    dg_wdata = add_sum[SW] ? {SW{1'b1}} : add_sum[SW-1:0];
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.bits     = mod_arg;
    div_req.divisor  = DW'(hop_q);

    unique case (st_q)
      gpdw_pkg::ST_IDLE: begin
        if (s_acc && s_axis_tuser[0] == gpdw_pkg::KIND_LOAD) begin
          if (ld_start) begin
            vld_d = '0;
            ec_d  = 11'd0;
          end
          win_we  = 1'b1;
          p_d     = ld_p;
          upper_d = upper_now;
          sq_d    = 32'($signed(s_axis_tdata) * $signed(s_axis_tdata));
          if (hop_ok) begin
            div_req.start = 1'b1;
            st_d = gpdw_pkg::ST_LD_MOD;
          end else begin
            lc_d = ld_p + 11'd1;
          end
        end else if (s_acc) begin
          if (!len_ok) begin
            res_d  = '0;
            last_d = 1'b0;
            rerr_d = gpdw_pkg::ERR_NOT_FRAME;
            st_d   = gpdw_pkg::ST_EM_OUT;
          end else begin
            last_d   = (em_p == len_q - 11'd1);
            ec_d     = (em_p == len_q - 11'd1) ? 11'd0 : em_p + 11'd1;
            p_d      = em_p;
            upper_d  = upper_now;
            win_re   = 1'b1;
            win_addr = AW'(em_p);
            res_d    = '0;
            rerr_d   = chk_err;
            if (chk_err != gpdw_pkg::ERR_OK) begin
              st_d = gpdw_pkg::ST_EM_OUT;
            end else begin
              div_req.start = 1'b1;
              st_d = gpdw_pkg::ST_EM_MOD;
            end
          end
        end
      end
      gpdw_pkg::ST_LD_MOD: begin
        if (div_rsp.done) begin
          dg_re = 1'b1;
          bin_d = HW'(bin9);
          st_d  = gpdw_pkg::ST_LD_WR;
        end
      end
      gpdw_pkg::ST_LD_WR: begin
        dg_we        = 1'b1;
        vld_d[bin_q] = 1'b1;
        lc_d         = p_q + 11'd1;
        st_d         = gpdw_pkg::ST_IDLE;
      end
      gpdw_pkg::ST_EM_MOD: begin
        if (div_rsp.done) begin
          dg_re = 1'b1;
          bin_d = HW'(bin9);
          st_d  = gpdw_pkg::ST_EM_MUL_LO;
        end
      end
      gpdw_pkg::ST_EM_MUL_LO: begin
        sum_d    = cur_sum;
        smp_d    = win_rdata;
        den_lo_d = ch_q * cur_sum[23:0];
        st_d     = gpdw_pkg::ST_EM_MUL_HI;
      end
      gpdw_pkg::ST_EM_MUL_HI: begin
        den_d = DW'(den_lo_q) + (DW'(ch_q * sum_q[SW-1:24]) << 24);
        st_d  = gpdw_pkg::ST_EM_CHK;
      end
      gpdw_pkg::ST_EM_CHK: begin
        div_req.rem_init = (DW + 1)'({mag, 7'd0});
        div_req.bits     = '0;
        div_req.divisor  = den_q;
        if (den_q == '0) begin
          rerr_d = gpdw_pkg::ERR_ZERO_DIAG;
          st_d   = gpdw_pkg::ST_EM_OUT;
        end else if (DW'({mag, 7'd0}) >= den_q) begin
          // quotient beyond 32 bits
          res_d = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          st_d  = gpdw_pkg::ST_EM_OUT;
        end else begin
          div_req.start = 1'b1;
          st_d = gpdw_pkg::ST_EM_DIV;
        end
      end
      gpdw_pkg::ST_EM_DIV: begin
        if (div_rsp.done) begin
          if (neg) begin
            res_d = (q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
          end else begin
            res_d = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
          end
          st_d = gpdw_pkg::ST_EM_OUT;
        end
      end
      gpdw_pkg::ST_EM_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = res_q;
          ol_d = last_q;
          oe_d = rerr_q;
          st_d = gpdw_pkg::ST_IDLE;
        end
      end
      default: st_d = gpdw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= gpdw_pkg::ST_IDLE;
      lc_q  <= 11'd0;
      ec_q  <= 11'd0;
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      lc_q  <= lc_d;
      ec_q  <= ec_d;
      vld_q <= vld_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    upper_q  <= upper_d;
    sq_q     <= sq_d;
    bin_q    <= bin_d;
    last_q   <= last_d;
    sum_q    <= sum_d;
    smp_q    <= smp_d;
    den_lo_q <= den_lo_d;
    den_q    <= den_d;
    res_q    <= res_d;
    rerr_q   <= rerr_d;
    od_q     <= od_d;
    ol_q     <= ol_d;
    oe_q     <= oe_d;
  end

  gpdw_ram #(.Width(16), .Depth(MAX_LEN)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_addr),
    .wdata_i (s_axis_tdata),
    .re_i    (win_re),
    .raddr_i (win_addr),
    .rdata_o (win_rdata)
  );

  gpdw_ram #(.Width(SW), .Depth(MAX_HOP)) u_diag_ram (
    .clk_i   (clk_i),
    .we_i    (dg_we),
    .waddr_i (bin_q),
    .wdata_i (dg_wdata),
    .re_i    (dg_re),
    .raddr_i (dg_raddr),
    .rdata_o (dg_rdata)
  );

  gpdw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = oe_q;

  `GPDW_ASSERT(a_emit_count_range, (32'(ec_q) <= MAX_LEN), "emit position past window store")
  `GPDW_ASSERT(a_bin_in_range, dg_we |-> (9'(bin_q) < hop_q), "bin write outside hop range")
  `GPDW_ASSERT_NEVER(a_div_overlap, div_req.start && div_rsp.busy, "divider restarted while busy")

endmodule
